>>> design/tacs_pkg.sv
// Package for the three-axis command shaper: types, constants and the
// control store holding the microprogram. No dependencies.
`default_nettype none

package tacs_pkg;

  localparam int UPC_W = 5;

  typedef logic [UPC_W-1:0] upc_t;

  localparam logic [15:0] RATE_RESET   = 16'd256;
  localparam logic [14:0] THRESH_RESET = 15'd164;
  localparam logic [15:0] RECIP3       = 16'd43691;

  localparam logic [2:0] REG_DRIVE_RATE_A  = 3'd0;
  localparam logic [2:0] REG_DECAY_RATE_A  = 3'd1;
  localparam logic [2:0] REG_DRIVE_RATE_B  = 3'd2;
  localparam logic [2:0] REG_DECAY_RATE_B  = 3'd3;
  localparam logic [2:0] REG_DRIVE_RATE_C  = 3'd4;
  localparam logic [2:0] REG_DECAY_RATE_C  = 3'd5;
  localparam logic [2:0] REG_THRESHOLD     = 3'd6;
  localparam logic [2:0] REG_TIMER_FACTOR  = 3'd7;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_RATE,
    OP_SQ,
    OP_CURVE,
    OP_DIV3,
    OP_GAP,
    OP_LAG_LO,
    OP_LAG_HI,
    OP_LAG_SUM,
    OP_LAG_APPLY,
    OP_DECAY,
    OP_TDEC,
    OP_BSTEP,
    OP_DONE
  } op_t;

  typedef enum logic [1:0] {
    AXIS_A,
    AXIS_B,
    AXIS_C
  } axis_t;

  typedef enum logic [1:0] {
    JMP_NONE,
    JMP_UNDRIVEN,
    JMP_ALWAYS
  } jmp_t;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_t;

  typedef struct packed {
    op_t   op;
    axis_t axis;
    jmp_t  jmp;
    upc_t  target;
  } uword_t;

  typedef struct packed {
    logic  load;
    op_t   op;
    axis_t axis;
  } dp_ctl_t;

  typedef struct packed {
    logic [15:0] drive_rate_a;
    logic [15:0] decay_rate_a;
    logic [15:0] drive_rate_b;
    logic [15:0] decay_rate_b;
    logic [15:0] drive_rate_c;
    logic [15:0] decay_rate_c;
    logic [14:0] command_threshold;
    logic [15:0] timer_decay_factor;
  } cfg_t;

  // microprogram entry points
  localparam upc_t UPC_DECAY_A = 5'd9;
  localparam upc_t UPC_B       = 5'd10;
  localparam upc_t UPC_DECAY_B = 5'd13;
  localparam upc_t UPC_C       = 5'd14;
  localparam upc_t UPC_DECAY_C = 5'd23;
  localparam upc_t UPC_DONE    = 5'd24;

  function automatic uword_t mk_uword(op_t op, axis_t ax, jmp_t jmp, upc_t target);
    uword_t w;
    w.op     = op;
    w.axis   = ax;
    w.jmp    = jmp;
    w.target = target;
    return w;
  endfunction

  function automatic uword_t ucode(upc_t addr);
    uword_t w;
    w = mk_uword(OP_DONE, AXIS_A, JMP_NONE, UPC_DONE);
    unique case (addr)
      5'd0:  w = mk_uword(OP_RATE,      AXIS_A, JMP_UNDRIVEN, UPC_DECAY_A);
      5'd1:  w = mk_uword(OP_SQ,        AXIS_A, JMP_NONE,     UPC_DONE);
      5'd2:  w = mk_uword(OP_CURVE,     AXIS_A, JMP_NONE,     UPC_DONE);
      5'd3:  w = mk_uword(OP_DIV3,      AXIS_A, JMP_NONE,     UPC_DONE);
      5'd4:  w = mk_uword(OP_GAP,       AXIS_A, JMP_NONE,     UPC_DONE);
      5'd5:  w = mk_uword(OP_LAG_LO,    AXIS_A, JMP_NONE,     UPC_DONE);
      5'd6:  w = mk_uword(OP_LAG_HI,    AXIS_A, JMP_NONE,     UPC_DONE);
      5'd7:  w = mk_uword(OP_LAG_SUM,   AXIS_A, JMP_NONE,     UPC_DONE);
      5'd8:  w = mk_uword(OP_LAG_APPLY, AXIS_A, JMP_ALWAYS,   UPC_B);
      5'd9:  w = mk_uword(OP_DECAY,     AXIS_A, JMP_NONE,     UPC_DONE);
      5'd10: w = mk_uword(OP_RATE,      AXIS_B, JMP_UNDRIVEN, UPC_DECAY_B);
      5'd11: w = mk_uword(OP_TDEC,      AXIS_B, JMP_NONE,     UPC_DONE);
      5'd12: w = mk_uword(OP_BSTEP,     AXIS_B, JMP_ALWAYS,   UPC_C);
      5'd13: w = mk_uword(OP_DECAY,     AXIS_B, JMP_NONE,     UPC_DONE);
      5'd14: w = mk_uword(OP_RATE,      AXIS_C, JMP_UNDRIVEN, UPC_DECAY_C);
      5'd15: w = mk_uword(OP_SQ,        AXIS_C, JMP_NONE,     UPC_DONE);
      5'd16: w = mk_uword(OP_CURVE,     AXIS_C, JMP_NONE,     UPC_DONE);
      5'd17: w = mk_uword(OP_DIV3,      AXIS_C, JMP_NONE,     UPC_DONE);
      5'd18: w = mk_uword(OP_GAP,       AXIS_C, JMP_NONE,     UPC_DONE);
      5'd19: w = mk_uword(OP_LAG_LO,    AXIS_C, JMP_NONE,     UPC_DONE);
      5'd20: w = mk_uword(OP_LAG_HI,    AXIS_C, JMP_NONE,     UPC_DONE);
      5'd21: w = mk_uword(OP_LAG_SUM,   AXIS_C, JMP_NONE,     UPC_DONE);
      5'd22: w = mk_uword(OP_LAG_APPLY, AXIS_C, JMP_ALWAYS,   UPC_DONE);
      5'd23: w = mk_uword(OP_DECAY,     AXIS_C, JMP_NONE,     UPC_DONE);
      default: w = mk_uword(OP_DONE,    AXIS_A, JMP_NONE,     UPC_DONE);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

>>> design/tacs_ifs.sv
// Valid/ready channel interfaces for frames in and shaped results out.
// Depends on nothing.
`default_nettype none

interface tacs_frame_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] cmd_axis_a;
  logic signed [15:0] cmd_axis_b;
  logic signed [15:0] cmd_axis_c;
  logic [15:0]        step_time;

  modport source (output valid, cmd_axis_a, cmd_axis_b, cmd_axis_c, step_time,
                  input ready);
  modport sink   (input valid, cmd_axis_a, cmd_axis_b, cmd_axis_c, step_time,
                  output ready);
endinterface

interface tacs_result_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] axis_a;
  logic signed [15:0] axis_b;
  logic signed [15:0] axis_c;
  logic [31:0]        hold_positive_time;
  logic [31:0]        hold_negative_time;

  modport source (output valid, axis_a, axis_b, axis_c, hold_positive_time,
                  hold_negative_time, input ready);
  modport sink   (input valid, axis_a, axis_b, axis_c, hold_positive_time,
                  hold_negative_time, output ready);
endinterface

`default_nettype wire

>>> design/three_axis_command_shaper_top.sv
// A frame runs as microcode steps up to a done step, which waits while a result is held;
// a lagging axis runs rate, square, curve, div3, gap, lag lo/hi, sum and apply on the
// shared 17x16 multiplier, a decaying axis rate and decay, a driven axis B rate, tdec
// and step. The next frame is taken while the prior result waits in the output register.
// Reset (rst, synchronous): axis values and hold timers zero, registers to
// their defaults, sequencer idle, frame ready low, no result valid.
`default_nettype none

module three_axis_command_shaper_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  tacs_frame_if.sink       frame,
  tacs_result_if.source    result
);

  tacs_pkg::cfg_t    cfg;
  tacs_pkg::dp_ctl_t ctl;

  logic               driven;
  logic               result_load;
  logic               result_hold;
  logic               res_valid;
  logic signed [15:0] value_a, value_b, value_c;
  logic [31:0]        timer_positive, timer_negative;
  logic signed [15:0] res_a, res_b, res_c;
  logic [31:0]        res_tp, res_tn;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.drive_rate_a       <= tacs_pkg::RATE_RESET;
      cfg.decay_rate_a       <= tacs_pkg::RATE_RESET;
      cfg.drive_rate_b       <= tacs_pkg::RATE_RESET;
      cfg.decay_rate_b       <= tacs_pkg::RATE_RESET;
      cfg.drive_rate_c       <= tacs_pkg::RATE_RESET;
      cfg.decay_rate_c       <= tacs_pkg::RATE_RESET;
      cfg.command_threshold  <= tacs_pkg::THRESH_RESET;
      cfg.timer_decay_factor <= tacs_pkg::RATE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        tacs_pkg::REG_DRIVE_RATE_A: cfg.drive_rate_a       <= cfg_data;
        tacs_pkg::REG_DECAY_RATE_A: cfg.decay_rate_a       <= cfg_data;
        tacs_pkg::REG_DRIVE_RATE_B: cfg.drive_rate_b       <= cfg_data;
        tacs_pkg::REG_DECAY_RATE_B: cfg.decay_rate_b       <= cfg_data;
        tacs_pkg::REG_DRIVE_RATE_C: cfg.drive_rate_c       <= cfg_data;
        tacs_pkg::REG_DECAY_RATE_C: cfg.decay_rate_c       <= cfg_data;
        tacs_pkg::REG_THRESHOLD:    cfg.command_threshold  <= cfg_data[14:0];
        tacs_pkg::REG_TIMER_FACTOR: cfg.timer_decay_factor <= cfg_data;
        default: ;
      endcase
    end
  end

  assign result_hold = res_valid && !result.ready;

  tacs_sequencer u_seq (
    .clk         (clk),
    .rst         (rst),
    .frame_valid (frame.valid),
    .result_hold (result_hold),
    .driven      (driven),
    .ctl         (ctl),
    .frame_ready (frame.ready),
    .result_load (result_load)
  );

  tacs_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .cfg            (cfg),
    .cmd_axis_a     (frame.cmd_axis_a),
    .cmd_axis_b     (frame.cmd_axis_b),
    .cmd_axis_c     (frame.cmd_axis_c),
    .step_time      (frame.step_time),
    .driven         (driven),
    .value_a        (value_a),
    .value_b        (value_b),
    .value_c        (value_c),
    .timer_positive (timer_positive),
    .timer_negative (timer_negative)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (result_load) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      res_a  <= value_a;
      res_b  <= value_b;
      res_c  <= value_c;
      res_tp <= timer_positive;
      res_tn <= timer_negative;
    end
  end

  assign result.valid              = res_valid;
  assign result.axis_a             = res_a;
  assign result.axis_b             = res_b;
  assign result.axis_c             = res_c;
  assign result.hold_positive_time = res_tp;
  assign result.hold_negative_time = res_tn;

endmodule

`default_nettype wire

>>> design/tacs_sequencer.sv
// Microprogram sequencer: step counter, control store lookup, conditional jumps
// and frame/result handshake control. Depends on tacs_pkg.
`default_nettype none

module tacs_sequencer (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            frame_valid,
  input  wire logic            result_hold,
  input  wire logic            driven,
  output tacs_pkg::dp_ctl_t    ctl,
  output logic                 frame_ready,
  output logic                 result_load
);

  tacs_pkg::seq_state_t state, state_next;
  tacs_pkg::upc_t       upc, upc_next;
  tacs_pkg::uword_t     uw;

  assign uw = tacs_pkg::ucode(upc);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tacs_pkg::SEQ_IDLE;
      upc   <= '0;
    end else begin
      state <= state_next;
      upc   <= upc_next;
    end
  end

  always_comb begin
    state_next  = state;
    upc_next    = upc;
    ctl.load    = 1'b0;
    ctl.op      = tacs_pkg::OP_NOP;
    ctl.axis    = tacs_pkg::AXIS_A;
    frame_ready = 1'b0;
    result_load = 1'b0;
    unique case (state)
      tacs_pkg::SEQ_IDLE: begin
        frame_ready = !rst;
        if (frame_valid && !rst) begin
          ctl.load   = 1'b1;
          upc_next   = '0;
          state_next = tacs_pkg::SEQ_RUN;
        end
      end
      tacs_pkg::SEQ_RUN: begin
        ctl.op   = uw.op;
        ctl.axis = uw.axis;
        if (uw.op == tacs_pkg::OP_DONE) begin
          if (!result_hold) begin
            result_load = 1'b1;
            state_next  = tacs_pkg::SEQ_IDLE;
          end
        end else begin
          case (uw.jmp)
            tacs_pkg::JMP_ALWAYS:   upc_next = uw.target;
            tacs_pkg::JMP_UNDRIVEN: upc_next = driven ? upc + 1'b1 : uw.target;
            default:                upc_next = upc + 1'b1;
          endcase
        end
      end
      default: state_next = tacs_pkg::SEQ_IDLE;
    endcase
  end

endmodule

`default_nettype wire

>>> design/tacs_datapath.sv
// Shaper datapath: one shared 17x16 multiplier, working registers, axis state
// and hold timers, driven by control words. Depends on tacs_pkg.
`default_nettype none

module tacs_datapath (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire tacs_pkg::dp_ctl_t  ctl,
  input  wire tacs_pkg::cfg_t     cfg,
  input  wire logic signed [15:0] cmd_axis_a,
  input  wire logic signed [15:0] cmd_axis_b,
  input  wire logic signed [15:0] cmd_axis_c,
  input  wire logic [15:0]        step_time,
  output logic                    driven,
  output logic signed [15:0]      value_a,
  output logic signed [15:0]      value_b,
  output logic signed [15:0]      value_c,
  output logic [31:0]             timer_positive,
  output logic [31:0]             timer_negative
);

  localparam logic signed [26:0] UNIT_POS = 27'sd16384;
  localparam logic signed [26:0] UNIT_NEG = -27'sd16384;

  function automatic logic signed [15:0] sat_cmd(logic signed [15:0] c);
    logic signed [15:0] r;
    r = c;
    if (c > 16'sd16384) r = 16'sd16384;
    if (c < -16'sd16384) r = -16'sd16384;
    return r;
  endfunction

  function automatic logic signed [15:0] sat_unit(logic signed [26:0] v);
    logic signed [15:0] r;
    r = v[15:0];
    if (v > UNIT_POS) r = 16'sd16384;
    if (v < UNIT_NEG) r = -16'sd16384;
    return r;
  endfunction

  // latched frame
  logic signed [15:0] cmd_a, cmd_b, cmd_c;
  logic [15:0]        step;

  // working registers
  logic [31:0] p_rate;
  logic [32:0] prod;
  logic [48:0] acc;
  logic [16:0] curve_x;
  logic [16:0] ag3;
  logic        gap_neg;

  // selection
  logic signed [15:0] cmd_sel, val_sel;
  logic [15:0]        cmd_abs, val_abs16;
  logic [14:0]        mag_sel, val_abs;
  logic [15:0]        drive_sel, decay_sel, rate_sel;

  // multiplier
  logic [16:0] mul_a;
  logic [15:0] mul_b;
  logic [32:0] mul_p;

  // step logic
  logic [28:0]        sq_rnd;
  logic [15:0]        curve_t;
  logic [14:0]        tgt;
  logic signed [17:0] tgt_s, gap;
  logic [17:0]        gap_abs;
  logic [15:0]        ag;
  logic [16:0]        ag3_next;
  logic [49:0]        lag_rnd;
  logic [24:0]        delta;
  logic signed [26:0] v27, lag_r;
  logic [32:0]        dec_sum;
  logic [22:0]        amt;
  logic [15:0]        decay_new;
  logic signed [26:0] vb27, bstep_r;
  logic [32:0]        tdec_sum;
  logic [24:0]        tdec;
  logic [32:0]        tp_add, tn_add;
  logic [31:0]        tp_inc, tn_inc, tp_dec, tn_dec;
  logic               b_pos, b_neg;
  logic signed [15:0] value_new;
  logic               value_we;

  always_comb begin
    case (ctl.axis)
      tacs_pkg::AXIS_B: begin
        cmd_sel   = cmd_b;
        val_sel   = value_b;
        drive_sel = cfg.drive_rate_b;
        decay_sel = cfg.decay_rate_b;
      end
      tacs_pkg::AXIS_C: begin
        cmd_sel   = cmd_c;
        val_sel   = value_c;
        drive_sel = cfg.drive_rate_c;
        decay_sel = cfg.decay_rate_c;
      end
      default: begin
        cmd_sel   = cmd_a;
        val_sel   = value_a;
        drive_sel = cfg.drive_rate_a;
        decay_sel = cfg.decay_rate_a;
      end
    endcase
  end

  assign cmd_abs   = cmd_sel[15] ? 16'(-cmd_sel) : 16'(cmd_sel);
  assign mag_sel   = cmd_abs[14:0];
  assign driven    = (mag_sel >= cfg.command_threshold);
  assign rate_sel  = driven ? drive_sel : decay_sel;
  assign val_abs16 = val_sel[15] ? 16'(-val_sel) : 16'(val_sel);
  assign val_abs   = val_abs16[14:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctl.op)
      tacs_pkg::OP_RATE: begin
        mul_a = {1'b0, rate_sel};
        mul_b = step;
      end
      tacs_pkg::OP_SQ: begin
        mul_a = {2'b0, mag_sel};
        mul_b = {1'b0, mag_sel};
      end
      tacs_pkg::OP_DIV3: begin
        mul_a = curve_x;
        mul_b = tacs_pkg::RECIP3;
      end
      tacs_pkg::OP_LAG_LO: begin
        mul_a = ag3;
        mul_b = p_rate[15:0];
      end
      tacs_pkg::OP_LAG_HI: begin
        mul_a = ag3;
        mul_b = p_rate[31:16];
      end
      tacs_pkg::OP_TDEC: begin
        mul_a = {1'b0, cfg.timer_decay_factor};
        mul_b = step;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // curve: t = m + round(m^2 >> 14), x = 2t + 1
  assign sq_rnd  = prod[28:0] + 29'd8192;
  assign curve_t = {1'b0, mag_sel} + {1'b0, sq_rnd[28:14]};

  // target = x/3 via reciprocal, signed gap to current value
  assign tgt      = prod[31:17];
  assign tgt_s    = cmd_sel[15] ? -$signed({3'b0, tgt}) : $signed({3'b0, tgt});
  assign gap      = tgt_s - $signed({{2{val_sel[15]}}, val_sel});
  assign gap_abs  = gap[17] ? 18'(-gap) : 18'(gap);
  assign ag       = gap_abs[15:0];
  assign ag3_next = {1'b0, ag} + {ag, 1'b0};

  // lag apply, round half away from zero
  assign lag_rnd = {1'b0, acc} + 50'd16777216;
  assign delta   = lag_rnd[49:25];
  assign v27     = {{11{val_sel[15]}}, val_sel};
  assign lag_r   = gap_neg ? v27 - $signed({2'b0, delta}) : v27 + $signed({2'b0, delta});

  // per-frame amount and decay toward zero
  assign dec_sum   = {1'b0, p_rate} + 33'd512;
  assign amt       = dec_sum[32:10];
  assign decay_new = ({8'b0, val_abs} <= amt) ? 16'd0 :
                     (val_sel[15] ? 16'(val_sel) + {1'b0, amt[14:0]}
                                  : 16'(val_sel) - {1'b0, amt[14:0]});

  // axis B step and hold timers
  assign b_pos   = !cmd_b[15] && (cmd_b != 16'sd0);
  assign b_neg   = cmd_b[15];
  assign vb27    = {{11{value_b[15]}}, value_b};
  assign bstep_r = b_pos ? vb27 + $signed({4'b0, amt}) :
                   b_neg ? vb27 - $signed({4'b0, amt}) : vb27;

  assign tdec_sum = {1'b0, prod[31:0]} + 33'd128;
  assign tdec     = tdec_sum[32:8];
  assign tp_add   = {1'b0, timer_positive} + {17'b0, step};
  assign tn_add   = {1'b0, timer_negative} + {17'b0, step};
  assign tp_inc   = tp_add[32] ? '1 : tp_add[31:0];
  assign tn_inc   = tn_add[32] ? '1 : tn_add[31:0];
  assign tp_dec   = ({7'b0, tdec} >= timer_positive) ? 32'd0 : timer_positive - {7'b0, tdec};
  assign tn_dec   = ({7'b0, tdec} >= timer_negative) ? 32'd0 : timer_negative - {7'b0, tdec};

  always_comb begin
    value_we  = 1'b0;
    value_new = val_sel;
    case (ctl.op)
      tacs_pkg::OP_LAG_APPLY: begin
        value_we  = 1'b1;
        value_new = sat_unit(lag_r);
      end
      tacs_pkg::OP_DECAY: begin
        value_we  = 1'b1;
        value_new = decay_new;
      end
      tacs_pkg::OP_BSTEP: begin
        value_we  = 1'b1;
        value_new = sat_unit(bstep_r);
      end
      default: begin
        value_we  = 1'b0;
        value_new = val_sel;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_a <= sat_cmd(cmd_axis_a);
      cmd_b <= sat_cmd(cmd_axis_b);
      cmd_c <= sat_cmd(cmd_axis_c);
      step  <= step_time;
    end
    case (ctl.op)
      tacs_pkg::OP_RATE:    p_rate  <= mul_p[31:0];
      tacs_pkg::OP_SQ:      prod    <= mul_p;
      tacs_pkg::OP_CURVE:   curve_x <= {curve_t, 1'b1};
      tacs_pkg::OP_DIV3:    prod    <= mul_p;
      tacs_pkg::OP_GAP: begin
        ag3     <= ag3_next;
        gap_neg <= gap[17];
      end
      tacs_pkg::OP_LAG_LO:  acc     <= {16'b0, mul_p};
      tacs_pkg::OP_LAG_HI:  prod    <= mul_p;
      tacs_pkg::OP_LAG_SUM: acc     <= acc + {prod[32:0], 16'b0};
      tacs_pkg::OP_TDEC:    prod    <= mul_p;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      value_a        <= '0;
      value_b        <= '0;
      value_c        <= '0;
      timer_positive <= '0;
      timer_negative <= '0;
    end else begin
      if (value_we) begin
        case (ctl.axis)
          tacs_pkg::AXIS_B: value_b <= value_new;
          tacs_pkg::AXIS_C: value_c <= value_new;
          default:          value_a <= value_new;
        endcase
      end
      if (ctl.op == tacs_pkg::OP_BSTEP) begin
        timer_positive <= b_pos ? tp_inc : tp_dec;
        timer_negative <= b_neg ? tn_inc : tn_dec;
      end
    end
  end

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for three_axis_command_shaper_top: directed table, then random
// frames under varied register settings with random idles on both sides.
// Depends on tacs_pkg, tacs_frame_if/tacs_result_if and the shaper top level.
`timescale 1ns / 1ps

module testbench;

  typedef struct packed {
    logic signed [15:0] ca;
    logic signed [15:0] cb;
    logic signed [15:0] cc;
    logic [15:0]        step;
  } frame_t;

  typedef struct packed {
    logic signed [15:0] axis_a;
    logic signed [15:0] axis_b;
    logic signed [15:0] axis_c;
    logic [31:0]        hold_pos;
    logic [31:0]        hold_neg;
  } shaped_t;

  typedef enum logic [1:0] {ROW_CFG, ROW_PREDICT, ROW_KNOWN} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [2:0]  reg_index;
    logic [15:0] reg_data;
    frame_t      item;
    shaped_t     known;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  tacs_frame_if  frame_ch ();
  tacs_result_if result_ch ();

  three_axis_command_shaper_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .frame     (frame_ch),
    .result    (result_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  tacs_pkg::cfg_t shaper_cfg;
  int             lvl_a, lvl_b, lvl_c;
  logic [31:0]    pos_hold, neg_hold;

  shaped_t     pending_shaped[$];
  plan_row_t   plan[$];
  int          mismatches = 0;
  int          b_run_left = 0;
  logic [15:0] b_run_cmd = '0;

  function automatic int sat_unit(longint v);
    if (v > 16384) return 16384;
    if (v < -16384) return -16384;
    return int'(v);
  endfunction

  function automatic bit is_driven(int c);
    int mag;
    mag = c < 0 ? -c : c;
    return mag >= int'(shaper_cfg.command_threshold);
  endfunction

  function automatic longint frame_amount(logic [15:0] rate, logic [15:0] step);
    return (longint'(rate) * longint'(step) + 512) >> 10;
  endfunction

  function automatic int toward_zero(int v, longint amount);
    longint r;
    r = v;
    if (r > 0) begin
      r = r - amount;
      if (r < 0) r = 0;
    end else if (r < 0) begin
      r = r + amount;
      if (r > 0) r = 0;
    end
    return int'(r);
  endfunction

  function automatic longint curve_target(int c);
    longint m, t, mag;
    m = c < 0 ? -c : c;
    t = m + ((m * m + 8192) >> 14);
    mag = (2 * t + 1) / 3;
    if (c > 0) return mag;
    if (c < 0) return -mag;
    return 0;
  endfunction

  function automatic int lag_toward(int v, int c, logic [15:0] rate, logic [15:0] step);
    longint gap, ag, delta;
    gap = curve_target(c) - v;
    ag = gap < 0 ? -gap : gap;
    delta = (3 * ag * longint'(rate) * longint'(step) + (longint'(1) << 24)) >> 25;
    return sat_unit(longint'(v) + (gap < 0 ? -delta : delta));
  endfunction

  function automatic logic [31:0] hold_add(logic [31:0] t, logic [15:0] amount);
    longint s;
    s = longint'(t) + longint'(amount);
    return s > longint'(32'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [31:0] hold_sub(logic [31:0] t, longint amount);
    return amount >= longint'(t) ? 32'd0 : t - amount[31:0];
  endfunction

  function automatic shaped_t shape_frame(frame_t f);
    int      ca, cb, cc;
    longint  tdec;
    shaped_t r;
    ca = sat_unit(longint'($signed(f.ca)));
    cb = sat_unit(longint'($signed(f.cb)));
    cc = sat_unit(longint'($signed(f.cc)));
    if (is_driven(ca)) lvl_a = lag_toward(lvl_a, ca, shaper_cfg.drive_rate_a, f.step);
    else lvl_a = toward_zero(lvl_a, frame_amount(shaper_cfg.decay_rate_a, f.step));
    if (is_driven(cb)) begin
      tdec = (longint'(shaper_cfg.timer_decay_factor) * longint'(f.step) + 128) >> 8;
      if (cb > 0) begin
        lvl_b = sat_unit(longint'(lvl_b) + frame_amount(shaper_cfg.drive_rate_b, f.step));
        pos_hold = hold_add(pos_hold, f.step);
      end else begin
        pos_hold = hold_sub(pos_hold, tdec);
      end
      if (cb < 0) begin
        lvl_b = sat_unit(longint'(lvl_b) - frame_amount(shaper_cfg.drive_rate_b, f.step));
        neg_hold = hold_add(neg_hold, f.step);
      end else begin
        neg_hold = hold_sub(neg_hold, tdec);
      end
    end else begin
      lvl_b = toward_zero(lvl_b, frame_amount(shaper_cfg.decay_rate_b, f.step));
    end
    if (is_driven(cc)) lvl_c = lag_toward(lvl_c, cc, shaper_cfg.drive_rate_c, f.step);
    else lvl_c = toward_zero(lvl_c, frame_amount(shaper_cfg.decay_rate_c, f.step));
    r.axis_a = 16'(lvl_a);
    r.axis_b = 16'(lvl_b);
    r.axis_c = 16'(lvl_c);
    r.hold_pos = pos_hold;
    r.hold_neg = neg_hold;
    return r;
  endfunction

  function automatic frame_t make_frame(int ca, int cb, int cc, int step);
    frame_t f;
    f.ca = 16'(ca);
    f.cb = 16'(cb);
    f.cc = 16'(cc);
    f.step = 16'(step);
    return f;
  endfunction

  function automatic plan_row_t predict_row(int ca, int cb, int cc, int step);
    plan_row_t r;
    r = '0;
    r.kind = ROW_PREDICT;
    r.item = make_frame(ca, cb, cc, step);
    return r;
  endfunction

  function automatic plan_row_t known_row(int ca, int cb, int cc, int step,
                                          int a, int b, int c, longint pos, longint neg);
    plan_row_t r;
    r = '0;
    r.kind = ROW_KNOWN;
    r.item = make_frame(ca, cb, cc, step);
    r.known.axis_a = 16'(a);
    r.known.axis_b = 16'(b);
    r.known.axis_c = 16'(c);
    r.known.hold_pos = pos[31:0];
    r.known.hold_neg = neg[31:0];
    return r;
  endfunction

  function automatic plan_row_t cfg_row(logic [2:0] idx, logic [15:0] data);
    plan_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.reg_index = idx;
    r.reg_data = data;
    return r;
  endfunction

  function automatic logic [15:0] pick_rate(int phase);
    int sel;
    sel = $urandom_range(0, 3);
    if (phase == 0) return 16'd0;
    if (phase == 1) return 16'hFFFF;
    if (sel == 0) return 16'($urandom_range(0, 512));
    if (sel == 1) return 16'($urandom_range(64, 2048));
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_threshold(int phase);
    logic top;
    top = 1'($urandom);
    if (phase == 0) return 16'd0;
    if (phase == 1) return 16'd16384;
    if (phase == 2) return {top, 15'($urandom_range(16385, 32767))};
    if ($urandom_range(0, 7) == 0) return {top, 15'd16384};
    return {top, 15'($urandom_range(0, 2000))};
  endfunction

  function automatic logic [15:0] random_cmd();
    int thr, v;
    thr = int'(shaper_cfg.command_threshold);
    case ($urandom_range(0, 15))
      0: v = 0;
      1, 2: v = int'($urandom_range(0, 65535));
      3: v = $urandom_range(0, 1) ? 16384 : -16384;
      4, 5: begin
        v = thr + int'($urandom_range(0, 2)) - 1;
        if ($urandom_range(0, 1)) v = -v;
      end
      default: v = int'($urandom_range(0, 32768)) - 16384;
    endcase
    return 16'(v);
  endfunction

  function automatic frame_t random_frame();
    frame_t f;
    // axis B holds one command for a run of frames so the hold timers build up
    if (b_run_left == 0) begin
      b_run_cmd = random_cmd();
      b_run_left = $urandom_range(1, 8);
    end
    b_run_left--;
    f.ca = random_cmd();
    f.cb = b_run_cmd;
    f.cc = random_cmd();
    case ($urandom_range(0, 7))
      0: f.step = 16'($urandom_range(0, 255));
      1: f.step = $urandom_range(0, 1) ? 16'hFFFF : 16'd0;
      default: f.step = 16'($urandom);
    endcase
    return f;
  endfunction

  task automatic send_frame(input frame_t f, input bit use_known, input shaped_t known);
    int      gap;
    shaped_t want;
    gap = $urandom_range(0, 4);
    if (gap > 0) begin
      frame_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    frame_ch.valid <= 1'b1;
    frame_ch.cmd_axis_a <= f.ca;
    frame_ch.cmd_axis_b <= f.cb;
    frame_ch.cmd_axis_c <= f.cc;
    frame_ch.step_time <= f.step;
    @(posedge clk);
    while (!frame_ch.ready) @(posedge clk);
    want = shape_frame(f);
    pending_shaped.push_back(use_known ? known : want);
  endtask

  task automatic wait_idle();
    frame_ch.valid <= 1'b0;
    while (pending_shaped.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      tacs_pkg::REG_DRIVE_RATE_A: shaper_cfg.drive_rate_a = data;
      tacs_pkg::REG_DECAY_RATE_A: shaper_cfg.decay_rate_a = data;
      tacs_pkg::REG_DRIVE_RATE_B: shaper_cfg.drive_rate_b = data;
      tacs_pkg::REG_DECAY_RATE_B: shaper_cfg.decay_rate_b = data;
      tacs_pkg::REG_DRIVE_RATE_C: shaper_cfg.drive_rate_c = data;
      tacs_pkg::REG_DECAY_RATE_C: shaper_cfg.decay_rate_c = data;
      tacs_pkg::REG_THRESHOLD:    shaper_cfg.command_threshold = data[14:0];
      tacs_pkg::REG_TIMER_FACTOR: shaper_cfg.timer_decay_factor = data;
      default: ;
    endcase
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t %s expected %h actual %h", $time, name, want, got);
    end
  endtask

  // result side
  initial begin
    int      stall;
    shaped_t want;
    while (rst) @(posedge clk);
    forever begin
      stall = $urandom_range(0, 4);
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      @(posedge clk);
      while (!result_ch.valid) @(posedge clk);
      if (pending_shaped.size() == 0) begin
        mismatches++;
        $display("%0t result expected none actual %h %h %h %h %h", $time,
                 result_ch.axis_a, result_ch.axis_b, result_ch.axis_c,
                 result_ch.hold_positive_time, result_ch.hold_negative_time);
      end else begin
        want = pending_shaped.pop_front();
        compare_field("axis_a", 32'(want.axis_a), 32'(result_ch.axis_a));
        compare_field("axis_b", 32'(want.axis_b), 32'(result_ch.axis_b));
        compare_field("axis_c", 32'(want.axis_c), 32'(result_ch.axis_c));
        compare_field("hold_positive_time", want.hold_pos, result_ch.hold_positive_time);
        compare_field("hold_negative_time", want.hold_neg, result_ch.hold_negative_time);
      end
    end
  end

  initial begin
    int items;
    cfg_write <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    frame_ch.valid <= 1'b0;
    frame_ch.cmd_axis_a <= '0;
    frame_ch.cmd_axis_b <= '0;
    frame_ch.cmd_axis_c <= '0;
    frame_ch.step_time <= '0;
    result_ch.ready <= 1'b0;
    shaper_cfg.drive_rate_a = tacs_pkg::RATE_RESET;
    shaper_cfg.decay_rate_a = tacs_pkg::RATE_RESET;
    shaper_cfg.drive_rate_b = tacs_pkg::RATE_RESET;
    shaper_cfg.decay_rate_b = tacs_pkg::RATE_RESET;
    shaper_cfg.drive_rate_c = tacs_pkg::RATE_RESET;
    shaper_cfg.decay_rate_c = tacs_pkg::RATE_RESET;
    shaper_cfg.command_threshold = tacs_pkg::THRESH_RESET;
    shaper_cfg.timer_decay_factor = tacs_pkg::RATE_RESET;
    lvl_a = 0;
    lvl_b = 0;
    lvl_c = 0;
    pos_hold = '0;
    neg_hold = '0;

    // directed table, starting from reset defaults
    plan.push_back(known_row(0, 0, 0, 0, 0, 0, 0, 0, 0));
    plan.push_back(known_row(0, 16384, 0, 65535, 0, 16384, 0, 65535, 0));
    plan.push_back(known_row(0, -32768, 0, 65535, 0, 0, 0, 0, 65535));
    plan.push_back(known_row(0, -16384, 0, 65535, 0, -16384, 0, 0, 131070));
    plan.push_back(known_row(0, -16384, 0, 65535, 0, -16384, 0, 0, 196605));
    plan.push_back(known_row(0, 163, 0, 65535, 0, 0, 0, 0, 196605));
    plan.push_back(known_row(16384, 0, -32768, 65535, 16384, 0, -16384, 0, 196605));
    plan.push_back(known_row(0, 0, 0, 65535, 0, 0, 0, 0, 196605));
    plan.push_back(cfg_row(tacs_pkg::REG_THRESHOLD, 16'd0));
    plan.push_back(known_row(0, 0, 0, 65535, 0, 0, 0, 0, 131070));
    plan.push_back(cfg_row(tacs_pkg::REG_THRESHOLD, 16'd16385));
    plan.push_back(known_row(16384, -16384, -32768, 65535, 0, 0, 0, 0, 131070));
    plan.push_back(cfg_row(tacs_pkg::REG_THRESHOLD, 16'hFFFF));
    plan.push_back(known_row(16384, -16384, -32768, 65535, 0, 0, 0, 0, 131070));
    plan.push_back(cfg_row(tacs_pkg::REG_THRESHOLD, 16'(tacs_pkg::THRESH_RESET)));
    plan.push_back(predict_row(5000, 200, -7000, 3000));
    plan.push_back(predict_row(-164, 164, 164, 1));
    plan.push_back(predict_row(-165, -163, 32767, 65535));
    plan.push_back(predict_row(16384, 16384, 16384, 40000));
    plan.push_back(predict_row(-16385, -300, 1, 255));
    plan.push_back(predict_row(8000, 8000, -8000, 12345));

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_CFG: begin
          wait_idle();
          write_reg(plan[i].reg_index, plan[i].reg_data);
          cfg_write <= 1'b0;
        end
        ROW_PREDICT: send_frame(plan[i].item, 1'b0, '0);
        default:     send_frame(plan[i].item, 1'b1, plan[i].known);
      endcase
    end

    // random frames: all rates zero, all rates max, never driven, then random settings
    for (int phase = 0; phase < 8; phase++) begin
      wait_idle();
      write_reg(tacs_pkg::REG_DRIVE_RATE_A, pick_rate(phase));
      write_reg(tacs_pkg::REG_DECAY_RATE_A, pick_rate(phase));
      write_reg(tacs_pkg::REG_DRIVE_RATE_B, pick_rate(phase));
      write_reg(tacs_pkg::REG_DECAY_RATE_B, pick_rate(phase));
      write_reg(tacs_pkg::REG_DRIVE_RATE_C, pick_rate(phase));
      write_reg(tacs_pkg::REG_DECAY_RATE_C, pick_rate(phase));
      write_reg(tacs_pkg::REG_THRESHOLD, pick_threshold(phase));
      write_reg(tacs_pkg::REG_TIMER_FACTOR, pick_rate(phase));
      cfg_write <= 1'b0;
      items = (phase == 2) ? 20 : 88;
      for (int n = 0; n < items; n++) send_frame(random_frame(), 1'b0, '0);
    end

    wait_idle();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("three_axis_command_shaper_top: match");
    end else begin
      $display("three_axis_command_shaper_top: mismatch");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("three_axis_command_shaper_top: mismatch");
    $finish;
  end

endmodule

>>> filelist.f
design/tacs_pkg.sv
design/tacs_ifs.sv
design/tacs_sequencer.sv
design/tacs_datapath.sv
design/three_axis_command_shaper_top.sv
tb/testbench.sv
